@@ hw/rtl/lrc_tlp_pkg.sv @@
// ----------------------------------------------------------------------------
// lrc_tlp_pkg
// Shared types, character codes and constants of the LRC timestamp parser.
// ----------------------------------------------------------------------------
package lrc_tlp_pkg;

    localparam int LINE_COUNT_MAX = 256;
    localparam int MAX_TEXT       = 255;

    localparam logic [8:0]  LINE_CAP        = 9'(LINE_COUNT_MAX);
    localparam logic [8:0]  LINE_LIMIT_RST  = 9'd256;
    localparam logic [7:0]  TEXT_CAP        = 8'(MAX_TEXT);
    localparam logic [13:0] ACC_MAX         = 14'd9999;
    localparam logic [2:0]  FRAC_DIGITS_MAX = 3'd7;
    localparam logic [2:0]  FRAC_DIV_DIGITS = 3'd3;

    // character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        KIND_TEXT   = 2'd0,
        KIND_COMMIT = 2'd1,
        KIND_COUNT  = 2'd2
    } kind_t;

    typedef enum logic [6:0] {
        PH_LINE_START = 7'b0000001,
        PH_SKIP_LINE  = 7'b0000010,
        PH_MIN        = 7'b0000100,
        PH_SEC        = 7'b0001000,
        PH_FRAC       = 7'b0010000,
        PH_SEEK       = 7'b0100000,
        PH_TEXT       = 7'b1000000
    } phase_t;

    typedef struct packed {
        kind_t       record_kind;
        logic [8:0]  line_number;
        logic [29:0] line_time_ms;
        logic [7:0]  char_out;
        logic [7:0]  line_length;
        logic        last_of_run;
    } record_t;

    // acc * 10 + d, saturating at 9999
    function automatic logic [13:0] acc_digit(input logic [13:0] acc, input logic [3:0] d);
        logic [17:0] v;
        v = 18'(acc) * 18'd10 + 18'(d);
        return (v > 18'(ACC_MAX)) ? ACC_MAX : v[13:0];
    endfunction

endpackage

@@ hw/rtl/lrc_tlp_in_if.sv @@
// ----------------------------------------------------------------------------
// lrc_tlp_in_if
// Text byte request channel of the LRC timestamp parser.
// ----------------------------------------------------------------------------
interface lrc_tlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

@@ hw/rtl/lrc_tlp_out_if.sv @@
// ----------------------------------------------------------------------------
// lrc_tlp_out_if
// Record channel of the LRC timestamp parser.
// ----------------------------------------------------------------------------
interface lrc_tlp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [8:0]  line_number;
    logic [29:0] line_time_ms;
    logic [7:0]  char_out;
    logic [7:0]  line_length;
    logic        last_of_run;

    modport source (output valid, output record_kind, output line_number,
                    output line_time_ms, output char_out, output line_length,
                    output last_of_run, input ready);
    modport sink   (input valid, input record_kind, input line_number,
                    input line_time_ms, input char_out, input line_length,
                    input last_of_run, output ready);
endinterface

@@ hw/rtl/lrc_tlp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// lrc_tlp_cfg_if
// Write channel for the line limit register.
// ----------------------------------------------------------------------------
interface lrc_tlp_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/lrc_timestamp_line_parser_top.sv @@
// ----------------------------------------------------------------------------
// lrc_timestamp_line_parser_top
// Records: the records of a byte are registered into the result queue as the byte is taken.
// Throughput: one byte per cycle while each byte yields at most one record and
// the receiver takes records; otherwise the single-record output port of the
// 4-entry result queue sets the rate, as a byte's records leave one at a time.
// Reset: parse state, line count and queue cleared, line limit set to 256.
// ----------------------------------------------------------------------------
module lrc_timestamp_line_parser_top (
    input  logic               clk,
    input  logic               rst_n,
    lrc_tlp_cfg_if.sink        cfg,
    lrc_tlp_in_if.sink         din,
    lrc_tlp_out_if.source      dout
);

    // configuration
    logic [8:0] line_limit_reg;

    // parse state
    lrc_tlp_pkg::phase_t phase_reg, phase_next;
    logic [13:0] min_reg, min_next;
    logic [13:0] sec_reg, sec_next;
    logic [13:0] frac_reg, frac_next;
    logic [2:0]  fdig_reg, fdig_next;
    logic [7:0]  tcnt_reg, tcnt_next;
    logic [8:0]  done_reg, done_next;

    // time terms, registered from the accumulators
    logic [29:0] min_ms_reg;
    logic [29:0] sec_ms_reg;
    logic [29:0] frac_ms_reg;
    logic [13:0] frac_sel;
    logic [29:0] time_sum;

    // result queue
    lrc_tlp_pkg::record_t fifo_reg [4];
    logic [1:0] head_reg;
    logic [2:0] cnt_reg;

    lrc_tlp_pkg::record_t res [3];
    logic [1:0] nres;
    logic [8:0] limit;
    logic [7:0] c;
    logic       is_digit;
    logic       in_fire;
    logic       out_fire;

    assign cfg.ready = 1'b1;
    assign din.ready = (cnt_reg <= 3'd1);
    assign in_fire   = din.valid & din.ready;
    assign out_fire  = dout.valid & dout.ready;

    assign c        = din.text_byte;
    assign is_digit = (c >= lrc_tlp_pkg::CH_ZERO) && (c <= lrc_tlp_pkg::CH_NINE);
    assign limit    = (line_limit_reg > lrc_tlp_pkg::LINE_CAP) ? lrc_tlp_pkg::LINE_CAP
                                                                : line_limit_reg;
    assign time_sum = min_ms_reg + sec_ms_reg + frac_ms_reg;

    // three-digit fraction: divide by ten via reciprocal, exact below 1029
    assign frac_sel = (fdig_reg == lrc_tlp_pkg::FRAC_DIV_DIGITS)
                    ? 14'((24'(frac_reg[9:0]) * 24'd205) >> 11)
                    : frac_reg;

    always_comb
    begin
        phase_next = phase_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        frac_next  = frac_reg;
        fdig_next  = fdig_reg;
        tcnt_next  = tcnt_reg;
        done_next  = done_reg;
        nres       = 2'd0;
        for (int i = 0; i < 3; i++)
        begin
            res[i] = '0;
        end

        if (done_reg < limit)
        begin
            unique case (phase_reg)
                lrc_tlp_pkg::PH_LINE_START:
                begin
                    if (c == lrc_tlp_pkg::CH_LF || c == lrc_tlp_pkg::CH_CR
                        || c == lrc_tlp_pkg::CH_SPACE)
                    begin
                        phase_next = lrc_tlp_pkg::PH_LINE_START;
                    end
                    else if (c == lrc_tlp_pkg::CH_LBR)
                    begin
                        min_next   = '0;
                        sec_next   = '0;
                        frac_next  = '0;
                        fdig_next  = '0;
                        tcnt_next  = '0;
                        phase_next = lrc_tlp_pkg::PH_MIN;
                    end
                    else
                    begin
                        phase_next = lrc_tlp_pkg::PH_SKIP_LINE;
                    end
                end
                lrc_tlp_pkg::PH_SKIP_LINE:
                begin
                    if (c == lrc_tlp_pkg::CH_LF)
                    begin
                        phase_next = lrc_tlp_pkg::PH_LINE_START;
                    end
                end
                lrc_tlp_pkg::PH_MIN:
                begin
                    if (is_digit)
                    begin
                        min_next = lrc_tlp_pkg::acc_digit(min_reg, c[3:0]);
                    end
                    else if (c == lrc_tlp_pkg::CH_COLON)
                    begin
                        phase_next = lrc_tlp_pkg::PH_SEC;
                    end
                    else if (c == lrc_tlp_pkg::CH_LF)
                    begin
                        phase_next = lrc_tlp_pkg::PH_LINE_START;
                    end
                    else
                    begin
                        phase_next = lrc_tlp_pkg::PH_SKIP_LINE;
                    end
                end
                lrc_tlp_pkg::PH_SEC, lrc_tlp_pkg::PH_FRAC, lrc_tlp_pkg::PH_SEEK:
                begin
                    if (is_digit && phase_reg == lrc_tlp_pkg::PH_SEC)
                    begin
                        sec_next = lrc_tlp_pkg::acc_digit(sec_reg, c[3:0]);
                    end
                    else if (c == lrc_tlp_pkg::CH_DOT && phase_reg == lrc_tlp_pkg::PH_SEC)
                    begin
                        phase_next = lrc_tlp_pkg::PH_FRAC;
                    end
                    else if (is_digit && phase_reg == lrc_tlp_pkg::PH_FRAC)
                    begin
                        frac_next = lrc_tlp_pkg::acc_digit(frac_reg, c[3:0]);
                        if (fdig_reg < lrc_tlp_pkg::FRAC_DIGITS_MAX)
                        begin
                            fdig_next = fdig_reg + 3'd1;
                        end
                    end
                    else if (c == lrc_tlp_pkg::CH_RBR)
                    begin
                        phase_next = lrc_tlp_pkg::PH_TEXT;
                        tcnt_next  = '0;
                    end
                    else
                    begin
                        phase_next = lrc_tlp_pkg::PH_SEEK;
                    end
                end
                lrc_tlp_pkg::PH_TEXT:
                begin
                    if (c == lrc_tlp_pkg::CH_LF || c == lrc_tlp_pkg::CH_CR)
                    begin
                        if (tcnt_reg != 8'd0)
                        begin
                            res[0].record_kind  = lrc_tlp_pkg::KIND_COMMIT;
                            res[0].line_number  = done_reg;
                            res[0].line_time_ms = time_sum;
                            res[0].line_length  = tcnt_reg;
                            nres                = 2'd1;
                            done_next           = done_reg + 9'd1;
                        end
                        tcnt_next  = '0;
                        phase_next = lrc_tlp_pkg::PH_LINE_START;
                    end
                    else
                    begin
                        res[0].record_kind = lrc_tlp_pkg::KIND_TEXT;
                        res[0].line_number = done_reg;
                        res[0].char_out    = c;
                        nres               = 2'd1;
                        tcnt_next          = tcnt_reg + 8'd1;
                        // full line commits with its last byte
                        if (tcnt_next >= lrc_tlp_pkg::TEXT_CAP)
                        begin
                            res[1].record_kind  = lrc_tlp_pkg::KIND_COMMIT;
                            res[1].line_number  = done_reg;
                            res[1].line_time_ms = time_sum;
                            res[1].line_length  = tcnt_next;
                            nres                = 2'd2;
                            done_next           = done_reg + 9'd1;
                            tcnt_next           = '0;
                            phase_next          = lrc_tlp_pkg::PH_LINE_START;
                        end
                    end
                end
                default:
                begin
                    phase_next = lrc_tlp_pkg::PH_LINE_START;
                end
            endcase
        end

        if (din.end_of_text)
        begin
            if (phase_next == lrc_tlp_pkg::PH_TEXT && tcnt_next != 8'd0)
            begin
                res[nres].record_kind  = lrc_tlp_pkg::KIND_COMMIT;
                res[nres].line_number  = done_next;
                res[nres].line_time_ms = time_sum;
                res[nres].line_length  = tcnt_next;
                nres                   = nres + 2'd1;
                done_next              = done_next + 9'd1;
            end
            res[nres].record_kind = lrc_tlp_pkg::KIND_COUNT;
            res[nres].line_number = done_next;
            nres                  = nres + 2'd1;
            phase_next = lrc_tlp_pkg::PH_LINE_START;
            min_next   = '0;
            sec_next   = '0;
            frac_next  = '0;
            fdig_next  = '0;
            tcnt_next  = '0;
            done_next  = '0;
        end

        if (nres != 2'd0)
        begin
            res[nres - 2'd1].last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= lrc_tlp_pkg::LINE_LIMIT_RST;
            phase_reg      <= lrc_tlp_pkg::PH_LINE_START;
            min_reg        <= '0;
            sec_reg        <= '0;
            frac_reg       <= '0;
            fdig_reg       <= '0;
            tcnt_reg       <= '0;
            done_reg       <= '0;
            min_ms_reg     <= '0;
            sec_ms_reg     <= '0;
            frac_ms_reg    <= '0;
            head_reg       <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                line_limit_reg <= cfg.data;
            end
            if (in_fire)
            begin
                phase_reg <= phase_next;
                min_reg   <= min_next;
                sec_reg   <= sec_next;
                frac_reg  <= frac_next;
                fdig_reg  <= fdig_next;
                tcnt_reg  <= tcnt_next;
                done_reg  <= done_next;
            end
            // accumulators settle before any commit, which follows the closing bracket and a text byte
            min_ms_reg  <= 30'(min_reg) * 30'd60000;
            sec_ms_reg  <= 30'(sec_reg) * 30'd1000;
            frac_ms_reg <= 30'(frac_sel) * 30'd10;
            if (out_fire)
            begin
                head_reg <= head_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + (in_fire ? 3'(nres) : 3'd0) - (out_fire ? 3'd1 : 3'd0);
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < nres)
                begin
                    fifo_reg[2'(head_reg + cnt_reg[1:0] + 2'(i))] <= res[i];
                end
            end
        end
    end

    assign dout.valid        = (cnt_reg != 3'd0);
    assign dout.record_kind  = fifo_reg[head_reg].record_kind;
    assign dout.line_number  = fifo_reg[head_reg].line_number;
    assign dout.line_time_ms = fifo_reg[head_reg].line_time_ms;
    assign dout.char_out     = fifo_reg[head_reg].char_out;
    assign dout.line_length  = fifo_reg[head_reg].line_length;
    assign dout.last_of_run  = fifo_reg[head_reg].last_of_run;

endmodule

@@ test/lrc_timestamp_line_parser_top_test.sv @@
// ----------------------------------------------------------------------------
// lrc_timestamp_line_parser_top_test
// Feeds LRC text bytes through the parser, predicts every text, commit and
// count record in a local model of the parse state, and checks the records
// in order. Covers blank skipping, metadata and broken lines, saturating
// numbers, the line limit, and back-pressure on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lrc_timestamp_line_parser_top_test;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_STALL  = 300;
    localparam int SETTLE      = 8;

    typedef struct {
        logic [7:0] value;
        logic       eot;
    } byte_req_t;

    logic clk;
    logic rst_n;

    lrc_tlp_cfg_if cfg_if ();
    lrc_tlp_in_if  din_if ();
    lrc_tlp_out_if dout_if ();

    lrc_timestamp_line_parser_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .din   (din_if),
        .dout  (dout_if)
    );

    byte_req_t            pending_bytes[$];
    lrc_tlp_pkg::record_t expected_records[$];
    lrc_tlp_pkg::record_t step_records[$];

    int bytes_queued   = 0;
    int bytes_accepted = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int src_gap        = 0;
    int sink_gap       = 0;
    int stall_left     = 0;
    int stall_reqs     = 0;
    int stall_served   = 0;
    bit idle_on        = 1'b0;

    // model of the parser state
    logic [8:0]          limit_reg   = lrc_tlp_pkg::LINE_LIMIT_RST;
    lrc_tlp_pkg::phase_t parse_state = lrc_tlp_pkg::PH_LINE_START;
    logic [13:0]         min_acc     = '0;
    logic [13:0]         sec_acc     = '0;
    logic [13:0]         frac_acc    = '0;
    logic [2:0]          frac_cnt    = '0;
    int                  text_len    = 0;
    logic [8:0]          lines_seen  = '0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic note_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
        $display("mismatch on %s: got %0d, want %0d", field, got, want);
        mismatch_count++;
    endtask

    function automatic logic [13:0] decimal_shift(input logic [13:0] acc, input logic [7:0] c);
        int unsigned v;
        v = 32'(acc) * 32'd10 + 32'(c - lrc_tlp_pkg::CH_ZERO);
        return (v > 32'(lrc_tlp_pkg::ACC_MAX)) ? lrc_tlp_pkg::ACC_MAX : v[13:0];
    endfunction

    function automatic lrc_tlp_pkg::record_t make_record(input lrc_tlp_pkg::kind_t kind,
                                                         input logic [8:0] line,
                                                         input logic [29:0] t,
                                                         input logic [7:0] ch,
                                                         input logic [7:0] len);
        lrc_tlp_pkg::record_t r;
        r.record_kind  = kind;
        r.line_number  = line;
        r.line_time_ms = t;
        r.char_out     = ch;
        r.line_length  = len;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    task automatic close_line();
        logic [13:0] f;
        int unsigned t;
        if (text_len > 0)
        begin
            f = (frac_cnt == lrc_tlp_pkg::FRAC_DIV_DIGITS) ? frac_acc / 14'd10 : frac_acc;
            t = 32'(min_acc) * 32'd60000 + 32'(sec_acc) * 32'd1000 + 32'(f) * 32'd10;
            step_records.push_back(make_record(lrc_tlp_pkg::KIND_COMMIT, lines_seen,
                                               t[29:0], 8'd0, 8'(text_len)));
            lines_seen++;
        end
        text_len    = 0;
        parse_state = lrc_tlp_pkg::PH_LINE_START;
    endtask

    task automatic seek_bracket(input logic [7:0] c);
        if (c == lrc_tlp_pkg::CH_RBR)
        begin
            parse_state = lrc_tlp_pkg::PH_TEXT;
            text_len    = 0;
        end
        else
            parse_state = lrc_tlp_pkg::PH_SEEK;
    endtask

    // advance the parser model by one byte and queue the records it yields
    task automatic predict_byte(input logic [7:0] c, input logic eot);
        logic [8:0] cap;
        bit         is_digit;
        step_records.delete();
        cap      = (limit_reg > lrc_tlp_pkg::LINE_CAP) ? lrc_tlp_pkg::LINE_CAP : limit_reg;
        is_digit = (c >= lrc_tlp_pkg::CH_ZERO) && (c <= lrc_tlp_pkg::CH_NINE);
        if (lines_seen < cap)
        begin
            case (parse_state)
                lrc_tlp_pkg::PH_LINE_START:
                    if (c == lrc_tlp_pkg::CH_LF || c == lrc_tlp_pkg::CH_CR
                        || c == lrc_tlp_pkg::CH_SPACE)
                        parse_state = lrc_tlp_pkg::PH_LINE_START;
                    else if (c == lrc_tlp_pkg::CH_LBR)
                    begin
                        min_acc     = '0;
                        sec_acc     = '0;
                        frac_acc    = '0;
                        frac_cnt    = '0;
                        text_len    = 0;
                        parse_state = lrc_tlp_pkg::PH_MIN;
                    end
                    else
                        parse_state = lrc_tlp_pkg::PH_SKIP_LINE;
                lrc_tlp_pkg::PH_SKIP_LINE:
                    if (c == lrc_tlp_pkg::CH_LF)
                        parse_state = lrc_tlp_pkg::PH_LINE_START;
                lrc_tlp_pkg::PH_MIN:
                    if (is_digit)
                        min_acc = decimal_shift(min_acc, c);
                    else if (c == lrc_tlp_pkg::CH_COLON)
                        parse_state = lrc_tlp_pkg::PH_SEC;
                    else
                        parse_state = (c == lrc_tlp_pkg::CH_LF) ? lrc_tlp_pkg::PH_LINE_START
                                                                : lrc_tlp_pkg::PH_SKIP_LINE;
                lrc_tlp_pkg::PH_SEC:
                    if (is_digit)
                        sec_acc = decimal_shift(sec_acc, c);
                    else if (c == lrc_tlp_pkg::CH_DOT)
                        parse_state = lrc_tlp_pkg::PH_FRAC;
                    else
                        seek_bracket(c);
                lrc_tlp_pkg::PH_FRAC:
                    if (is_digit)
                    begin
                        frac_acc = decimal_shift(frac_acc, c);
                        if (frac_cnt < lrc_tlp_pkg::FRAC_DIGITS_MAX)
                            frac_cnt++;
                    end
                    else
                        seek_bracket(c);
                lrc_tlp_pkg::PH_SEEK:
                    seek_bracket(c);
                lrc_tlp_pkg::PH_TEXT:
                    if (c == lrc_tlp_pkg::CH_LF || c == lrc_tlp_pkg::CH_CR)
                        close_line();
                    else
                    begin
                        step_records.push_back(make_record(lrc_tlp_pkg::KIND_TEXT,
                                                           lines_seen, '0, c, '0));
                        text_len++;
                        if (text_len >= int'(lrc_tlp_pkg::TEXT_CAP))
                            close_line();
                    end
                default:
                    parse_state = lrc_tlp_pkg::PH_LINE_START;
            endcase
        end
        if (eot)
        begin
            if (parse_state == lrc_tlp_pkg::PH_TEXT && text_len > 0)
                close_line();
            step_records.push_back(make_record(lrc_tlp_pkg::KIND_COUNT, lines_seen,
                                               '0, '0, '0));
            parse_state = lrc_tlp_pkg::PH_LINE_START;
            min_acc     = '0;
            sec_acc     = '0;
            frac_acc    = '0;
            frac_cnt    = '0;
            text_len    = 0;
            lines_seen  = '0;
        end
        if (step_records.size() > 0)
            step_records[step_records.size() - 1].last_of_run = 1'b1;
        foreach (step_records[i])
            expected_records.push_back(step_records[i]);
    endtask

    // byte request driver
    always @(posedge clk)
    begin : byte_driver
        byte_req_t nxt;
        if (!rst_n)
        begin
            din_if.valid <= 1'b0;
            src_gap      <= 0;
        end
        else
        begin
            if (din_if.valid && din_if.ready)
            begin
                predict_byte(din_if.text_byte, din_if.end_of_text);
                bytes_accepted++;
            end
            if (din_if.valid && !din_if.ready)
            begin
                // request still waiting, hold it
            end
            else if (src_gap > 0)
            begin
                src_gap      <= src_gap - 1;
                din_if.valid <= 1'b0;
            end
            else if (idle_on && pending_bytes.size() > 0 && $urandom_range(0, 9) == 0)
            begin
                src_gap      <= $urandom_range(0, 15);
                din_if.valid <= 1'b0;
            end
            else if (pending_bytes.size() > 0)
            begin
                nxt                = pending_bytes.pop_front();
                din_if.valid       <= 1'b1;
                din_if.text_byte   <= nxt.value;
                din_if.end_of_text <= nxt.eot;
            end
            else
                din_if.valid <= 1'b0;
        end
    end

    // long receiver hold-off, served on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stall_left   <= 0;
            stall_served <= 0;
        end
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (stall_served != stall_reqs)
        begin
            stall_left   <= LONG_STALL;
            stall_served <= stall_served + 1;
        end
    end

    // record monitor
    always @(posedge clk)
    begin : record_monitor
        lrc_tlp_pkg::record_t got;
        lrc_tlp_pkg::record_t want;
        if (!rst_n)
        begin
            dout_if.ready <= 1'b0;
            sink_gap      <= 0;
        end
        else
        begin
            if (dout_if.valid && dout_if.ready)
            begin
                got.record_kind  = lrc_tlp_pkg::kind_t'(dout_if.record_kind);
                got.line_number  = dout_if.line_number;
                got.line_time_ms = dout_if.line_time_ms;
                got.char_out     = dout_if.char_out;
                got.line_length  = dout_if.line_length;
                got.last_of_run  = dout_if.last_of_run;
                if (expected_records.size() == 0)
                    note_mismatch("unexpected record kind", got.record_kind, 0);
                else
                begin
                    want = expected_records.pop_front();
                    if (got.record_kind !== want.record_kind)
                        note_mismatch("record_kind", got.record_kind, want.record_kind);
                    if (got.line_number !== want.line_number)
                        note_mismatch("line_number", got.line_number, want.line_number);
                    if (got.line_time_ms !== want.line_time_ms)
                        note_mismatch("line_time_ms", got.line_time_ms, want.line_time_ms);
                    if (got.char_out !== want.char_out)
                        note_mismatch("char_out", got.char_out, want.char_out);
                    if (got.line_length !== want.line_length)
                        note_mismatch("line_length", got.line_length, want.line_length);
                    if (got.last_of_run !== want.last_of_run)
                        note_mismatch("last_of_run", got.last_of_run, want.last_of_run);
                end
            end
            if (stall_left > 0)
                dout_if.ready <= 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap      <= sink_gap - 1;
                dout_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                sink_gap      <= $urandom_range(0, 15);
                dout_if.ready <= 1'b0;
            end
            else
                dout_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("lrc_timestamp_line_parser_top_test: errors");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] v, input logic eot);
        byte_req_t r;
        r.value = v;
        r.eot   = eot;
        pending_bytes.push_back(r);
        bytes_queued++;
    endtask

    task automatic push_str(input string s);
        foreach (s[i])
            push_byte(s[i], 1'b0);
    endtask

    task automatic push_digits(input int n);
        repeat (n)
            push_byte(lrc_tlp_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    endtask

    function automatic logic [7:0] lyric_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == lrc_tlp_pkg::CH_LF || b == lrc_tlp_pkg::CH_CR);
        return b;
    endfunction

    task automatic push_line_end();
        case ($urandom_range(0, 2))
            0: push_byte(lrc_tlp_pkg::CH_LF, 1'b0);
            1: push_byte(lrc_tlp_pkg::CH_CR, 1'b0);
            default:
            begin
                push_byte(lrc_tlp_pkg::CH_CR, 1'b0);
                push_byte(lrc_tlp_pkg::CH_LF, 1'b0);
            end
        endcase
    endtask

    task automatic push_stamp();
        push_byte(lrc_tlp_pkg::CH_LBR, 1'b0);
        push_digits(($urandom_range(0, 9) == 0) ? 5 : $urandom_range(0, 2));
        push_byte(lrc_tlp_pkg::CH_COLON, 1'b0);
        push_digits(($urandom_range(0, 9) == 0) ? 5 : $urandom_range(0, 2));
        if ($urandom_range(0, 2) != 0)
        begin
            push_byte(lrc_tlp_pkg::CH_DOT, 1'b0);
            push_digits(($urandom_range(0, 9) == 0) ? 8 : $urandom_range(0, 4));
        end
    endtask

    // mostly timed lyric lines, the rest metadata, broken, untimed, blank and junk lines
    task automatic push_random_line();
        int pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 72)
        begin
            push_stamp();
            push_byte(lrc_tlp_pkg::CH_RBR, 1'b0);
            repeat (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8))
                push_byte(lyric_byte(), 1'b0);
            push_line_end();
        end
        else if (pick < 78)
        begin
            push_byte(lrc_tlp_pkg::CH_LBR, 1'b0);
            repeat ($urandom_range(1, 3))
                push_byte("a" + 8'($urandom_range(0, 25)), 1'b0);
            push_byte(lrc_tlp_pkg::CH_COLON, 1'b0);
            repeat ($urandom_range(0, 5))
                push_byte("a" + 8'($urandom_range(0, 25)), 1'b0);
            push_byte(lrc_tlp_pkg::CH_RBR, 1'b0);
            push_byte(lrc_tlp_pkg::CH_LF, 1'b0);
        end
        else if (pick < 84)
        begin
            // no closing bracket until somewhere further on
            push_stamp();
            repeat ($urandom_range(0, 4))
            begin
                b = lyric_byte();
                push_byte((b == lrc_tlp_pkg::CH_RBR) ? lrc_tlp_pkg::CH_SPACE : b, 1'b0);
            end
            push_line_end();
            push_byte(lrc_tlp_pkg::CH_RBR, 1'b0);
            repeat ($urandom_range(0, 3))
                push_byte(lyric_byte(), 1'b0);
            push_line_end();
        end
        else if (pick < 90)
        begin
            do
                b = lyric_byte();
            while (b == lrc_tlp_pkg::CH_LBR || b == lrc_tlp_pkg::CH_SPACE);
            push_byte(b, 1'b0);
            repeat ($urandom_range(0, 5))
                push_byte(lyric_byte(), 1'b0);
            push_byte(lrc_tlp_pkg::CH_LF, 1'b0);
        end
        else if (pick < 95)
        begin
            repeat ($urandom_range(1, 4))
                case ($urandom_range(0, 2))
                    0: push_byte(lrc_tlp_pkg::CH_SPACE, 1'b0);
                    1: push_byte(lrc_tlp_pkg::CH_CR, 1'b0);
                    default: push_byte(lrc_tlp_pkg::CH_LF, 1'b0);
                endcase
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                push_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic push_random_text(input int target);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < target)
            push_random_line();
        // sometimes end in the middle of a lyric line
        if ($urandom_range(0, 1) == 0)
        begin
            push_stamp();
            push_byte(lrc_tlp_pkg::CH_RBR, 1'b0);
            repeat ($urandom_range(0, 3))
                push_byte(lyric_byte(), 1'b0);
            push_byte(lyric_byte(), 1'b1);
        end
        else
            push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic wait_all_done();
        while (bytes_accepted != bytes_queued || expected_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_line_limit(input logic [8:0] v);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        limit_reg = v;
        cfg_if.valid <= 1'b0;
    endtask

    initial
    begin : main_seq
        rst_n              = 1'b0;
        din_if.valid       = 1'b0;
        din_if.text_byte   = '0;
        din_if.end_of_text = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        dout_if.ready      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n   <= 1'b1;
        idle_on <= 1'b1;

        // directed text at the reset line limit
        push_str(" \r\n[00:00.00]A\n");
        push_str("[99:59.999]");
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_str("\r\n[123456:7.12345678]x\r");
        push_str("[ar:someone]\nhello\n[5\n");
        push_str("[12:34 \nzz]hi\n[:.]\n[1:2]a");
        // last byte forwards, commits and counts
        push_byte("b", 1'b1);
        wait_all_done();

        write_line_limit(9'd1);
        push_str("[0:1]a\n[0:2]b\n");
        push_byte("x", 1'b1);
        wait_all_done();

        write_line_limit(9'd0);
        push_str("[0:3]c\n");
        push_byte("d", 1'b1);
        wait_all_done();

        // receiver holds off while the sender keeps offering
        write_line_limit(9'd400);
        push_random_text(8);
        stall_reqs <= stall_reqs + 1;
        wait_all_done();

        write_line_limit(9'($urandom_range(2, 4)));
        push_random_text(2);
        wait_all_done();

        write_line_limit(lrc_tlp_pkg::LINE_LIMIT_RST);
        idle_on <= 1'b0;
        push_random_text(2);
        wait_all_done();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_records.size() == 0)
            $display("lrc_timestamp_line_parser_top_test: clean");
        else
            $display("lrc_timestamp_line_parser_top_test: errors");
        $finish;
    end

endmodule
